@@ rtl/mbvc_pkg.sv @@
`timescale 1ns / 1ps
// package for the meter bcd value codec
// holds status and op codes, format constants, the signed group helper and the digit pair helper

package mbvc_pkg;

    localparam int unsigned VALUE_W = 28;
    localparam int unsigned BCD_W   = 32;
    localparam int unsigned STAGES  = 6;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_FORMAT = 2'd1,
        STATUS_BAD_DIGIT = 2'd2
    } status_t;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    localparam logic [27:0] UNSIGNED_MODULUS = 28'd100000000;
    localparam logic [27:0] SIGNED_MODULUS   = 28'd80000000;
    localparam int unsigned SIGN_BIT         = 31;

    localparam logic [7:0] GROUP_00 = 8'h00;
    localparam logic [7:0] GROUP_03 = 8'h03;
    localparam logic [7:0] GROUP_04 = 8'h04;
    localparam logic [7:0] GROUP_17 = 8'h17;
    localparam logic [7:0] GROUP_18 = 8'h18;
    localparam logic [7:0] GROUP_2B = 8'h2B;
    localparam logic [7:0] GROUP_2C = 8'h2C;
    localparam logic [7:0] GROUP_3F = 8'h3F;
    localparam logic [7:0] GROUP_40 = 8'h40;

    localparam logic [3:0]  DIGIT_MAX    = 4'd9;
    localparam logic [13:0] HUNDRED      = 14'd100;
    localparam logic [27:0] TEN_THOUSAND = 28'd10000;

    // floor(x / 10000) within one for x below 1e8
    localparam logic [15:0] RECIP_10K = 16'd53687;
    localparam int unsigned SHIFT_10K = 29;
    // exact floor(x / 100) for x below 43699
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned SHIFT_100 = 19;
    // exact floor(x / 10) for x below 179
    localparam logic [6:0]  RECIP_10  = 7'd103;
    localparam int unsigned SHIFT_10  = 10;

    function automatic logic group_is_signed(input logic [7:0] group);
        logic sgn;
        unique case (group)
            GROUP_00, GROUP_03, GROUP_04, GROUP_17, GROUP_18,
            GROUP_2B, GROUP_2C, GROUP_3F, GROUP_40: sgn = 1'b1;
            default:                                 sgn = 1'b0;
        endcase
        return sgn;
    endfunction

    // binary 0..99 to two packed bcd digits
    function automatic logic [7:0] pair_to_bcd(input logic [6:0] x);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 14'(x) * 14'(RECIP_10);
        tens = prod[SHIFT_10 +: 4];
        ones = x - 7'(7'(tens) * 7'd10);
        return {tens, ones[3:0]};
    endfunction

endpackage

@@ rtl/meter_bcd_value_codec_unit.sv @@
`timescale 1ns / 1ps
// meter bcd value codec: hundredths value <-> 8 digit packed bcd
// throughput one item per cycle; the six-stage pipeline stalls as a whole
// when the output item is not taken
// reset clears the stage valid bits only; uses mbvc_pkg

module meter_bcd_value_codec_unit
    import mbvc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic [7:0]                ident_top,
    input  logic [7:0]                ident_group,
    input  logic signed [VALUE_W-1:0] value_in,
    input  logic [BCD_W-1:0]          bcd_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [BCD_W-1:0]          bcd_out,
    output logic signed [VALUE_W-1:0] value_out,
    output logic [1:0]                status
);

    logic [STAGES-1:0] valid_reg;
    logic              advance;

    // per-stage shared control
    typedef struct packed {
        op_t     op;
        status_t status;
        logic    sign;
    } ctl_t;

    ctl_t ctl_next;
    ctl_t ctl_reg [STAGES];

    // stage 1
    logic [26:0]      s1_mag_next, s1_mag_reg;
    logic [3:0][6:0]  s1_pair_next, s1_pair_reg;
    // stage 2
    logic [13:0]      s2_q0_next, s2_q0_reg;
    logic [26:0]      s2_mag_reg;
    logic [1:0][13:0] s2_half_next, s2_half_reg;
    // stage 3
    logic [1:0][13:0] s3_quad_next, s3_quad_reg;
    logic [26:0]      s3_dmag_next, s3_dmag_reg;
    // stage 4
    logic [1:0][6:0]  s4_q_next, s4_q_reg;
    logic [1:0][13:0] s4_quad_reg;
    logic [27:0]      s4_value_next, s4_value_reg;
    // stage 5
    logic [3:0][6:0]  s5_pair_next, s5_pair_reg;
    logic [27:0]      s5_value_reg;
    // stage 6
    logic [BCD_W-1:0] s6_bcd_next, s6_bcd_reg;
    logic [27:0]      s6_value_next, s6_value_reg;

    assign advance  = ~valid_reg[STAGES-1] | out_ready;
    assign in_ready = advance;

    // stage 1: format, magnitude with modulo, digit check and digit pairs
    always_comb
    begin
        logic        sgn;
        logic        neg;
        logic [27:0] raw;
        logic [27:0] mag;
        logic [27:0] modulus;
        logic [27:0] wrapped;
        logic [31:0] digits;
        logic        bad;
        logic [7:0]  pair_sum;
        sgn     = group_is_signed(ident_group);
        raw     = value_in;
        neg     = raw[VALUE_W-1];
        mag     = neg ? (~raw + 28'd1) : raw;
        modulus = sgn ? SIGNED_MODULUS : UNSIGNED_MODULUS;
        wrapped = (mag >= modulus) ? (mag - modulus) : mag;
        s1_mag_next = wrapped[26:0];

        digits = bcd_in;
        if (sgn)
        begin
            digits[SIGN_BIT] = 1'b0;
        end
        bad = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            bad = bad | (digits[4*i +: 4] > DIGIT_MAX);
        end
        for (int b = 0; b < 4; b++)
        begin
            pair_sum = {1'b0, digits[8*b+4 +: 4], 3'b000}
                     + {3'b000, digits[8*b+4 +: 4], 1'b0}
                     + {4'b0000, digits[8*b +: 4]};
            s1_pair_next[b] = pair_sum[6:0];
        end

        ctl_next.op = op_t'(op);
        if (ident_top != 8'd0)
        begin
            ctl_next.status = STATUS_NO_FORMAT;
        end
        else if (op_t'(op) == OP_DECODE && bad)
        begin
            ctl_next.status = STATUS_BAD_DIGIT;
        end
        else
        begin
            ctl_next.status = STATUS_OK;
        end
        ctl_next.sign = (op_t'(op) == OP_DECODE) ? (sgn & bcd_in[SIGN_BIT]) : (sgn & neg);
    end

    // stage 2: quotient estimate by 10000, decode halves
    always_comb
    begin
        logic [42:0] prod;
        prod = 43'(s1_mag_reg) * 43'(RECIP_10K);
        s2_q0_next = prod[SHIFT_10K +: 14];
        for (int h = 0; h < 2; h++)
        begin
            s2_half_next[h] = 14'(s1_pair_reg[2*h+1]) * HUNDRED + 14'(s1_pair_reg[2*h]);
        end
    end

    // stage 3: remainder with correction, decode magnitude
    always_comb
    begin
        logic [27:0] prod;
        logic [27:0] rem;
        prod = 28'(s2_q0_reg) * TEN_THOUSAND;
        rem  = {1'b0, s2_mag_reg} - prod;
        if (rem >= TEN_THOUSAND)
        begin
            s3_quad_next[1] = s2_q0_reg + 14'd1;
            s3_quad_next[0] = 14'(rem - TEN_THOUSAND);
        end
        else
        begin
            s3_quad_next[1] = s2_q0_reg;
            s3_quad_next[0] = rem[13:0];
        end
        s3_dmag_next = 27'(27'(s2_half_reg[1]) * 27'(TEN_THOUSAND))
                     + 27'(s2_half_reg[0]);
    end

    // stage 4: quotients by 100, decode sign
    always_comb
    begin
        logic [26:0] prod;
        for (int h = 0; h < 2; h++)
        begin
            prod = 27'(s3_quad_reg[h]) * 27'(RECIP_100);
            s4_q_next[h] = prod[SHIFT_100 +: 7];
        end
        s4_value_next = ctl_reg[2].sign ? (~{1'b0, s3_dmag_reg} + 28'd1)
                                        : {1'b0, s3_dmag_reg};
    end

    // stage 5: remainders by 100, four binary digit pairs
    always_comb
    begin
        logic [13:0] rem;
        for (int h = 0; h < 2; h++)
        begin
            rem = s4_quad_reg[h] - 14'(s4_q_reg[h]) * HUNDRED;
            s5_pair_next[2*h]   = rem[6:0];
            s5_pair_next[2*h+1] = s4_q_reg[h];
        end
    end

    // stage 6: pairs to bcd, output select
    always_comb
    begin
        logic [BCD_W-1:0] bcd;
        for (int b = 0; b < 4; b++)
        begin
            bcd[8*b +: 8] = pair_to_bcd(s5_pair_reg[b]);
        end
        bcd[SIGN_BIT] = bcd[SIGN_BIT] | ctl_reg[4].sign;
        s6_bcd_next   = '0;
        s6_value_next = '0;
        if (ctl_reg[4].status == STATUS_OK)
        begin
            if (ctl_reg[4].op == OP_ENCODE)
            begin
                s6_bcd_next = bcd;
            end
            else
            begin
                s6_value_next = s5_value_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl_reg[0] <= ctl_next;
            for (int s = 1; s < STAGES; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
            s1_mag_reg   <= s1_mag_next;
            s1_pair_reg  <= s1_pair_next;
            s2_q0_reg    <= s2_q0_next;
            s2_mag_reg   <= s1_mag_reg;
            s2_half_reg  <= s2_half_next;
            s3_quad_reg  <= s3_quad_next;
            s3_dmag_reg  <= s3_dmag_next;
            s4_q_reg     <= s4_q_next;
            s4_quad_reg  <= s3_quad_reg;
            s4_value_reg <= s4_value_next;
            s5_pair_reg  <= s5_pair_next;
            s5_value_reg <= s4_value_reg;
            s6_bcd_reg   <= s6_bcd_next;
            s6_value_reg <= s6_value_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign bcd_out   = s6_bcd_reg;
    assign value_out = s6_value_reg;
    assign status    = ctl_reg[STAGES-1].status;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for meter_bcd_value_codec_unit
// predicts every result item from the accepted input item; uses mbvc_pkg types and constants

module testbench;
    import mbvc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 150;
    localparam int DRAIN       = 20;
    localparam int RANDOM_ITEMS = 600;

    typedef struct packed {
        op_t                      op;
        logic [7:0]               top;
        logic [7:0]               group;
        logic signed [VALUE_W-1:0] value;
        logic [BCD_W-1:0]         bcd;
    } codec_item_t;

    typedef struct packed {
        logic [BCD_W-1:0]         bcd;
        logic signed [VALUE_W-1:0] value;
        status_t                  status;
    } codec_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic in_fire = 1'b0;
    codec_item_t drive_item = '0;

    logic op;
    logic [7:0] ident_top;
    logic [7:0] ident_group;
    logic signed [VALUE_W-1:0] value_in;
    logic [BCD_W-1:0] bcd_in;
    logic [BCD_W-1:0] bcd_out;
    logic signed [VALUE_W-1:0] value_out;
    logic [1:0] status;

    codec_item_t pending_items[$];
    codec_result_t expected_results[$];

    int errors = 0;
    int items_accepted = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int send_burst = 0;
    int stall_left = 0;
    int recv_burst = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    logic [7:0] signed_groups [9] = '{GROUP_00, GROUP_03, GROUP_04, GROUP_17, GROUP_18,
                                      GROUP_2B, GROUP_2C, GROUP_3F, GROUP_40};

    assign op          = drive_item.op;
    assign ident_top   = drive_item.top;
    assign ident_group = drive_item.group;
    assign value_in    = drive_item.value;
    assign bcd_in      = drive_item.bcd;

    meter_bcd_value_codec_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .ident_top  (ident_top),
        .ident_group(ident_group),
        .value_in   (value_in),
        .bcd_in     (bcd_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bcd_out    (bcd_out),
        .value_out  (value_out),
        .status     (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic codec_result_t convert_item(input codec_item_t it);
        codec_result_t r;
        logic sgn;
        logic neg;
        logic [VALUE_W-1:0] mag;
        logic [31:0] m;
        logic [31:0] digits;
        logic [31:0] acc;
        logic [3:0] d;
        logic ok;
        r = '0;
        r.status = STATUS_OK;
        if (it.top != 8'h00)
        begin
            r.status = STATUS_NO_FORMAT;
        end
        else
        begin
            case (it.group)
                GROUP_00, GROUP_03, GROUP_04, GROUP_17, GROUP_18,
                GROUP_2B, GROUP_2C, GROUP_3F, GROUP_40: sgn = 1'b1;
                default: sgn = 1'b0;
            endcase
            if (it.op == OP_ENCODE)
            begin
                neg = it.value[VALUE_W-1];
                mag = neg ? (VALUE_W'(0) - it.value) : it.value;
                m = 32'(mag) % (sgn ? 32'(SIGNED_MODULUS) : 32'(UNSIGNED_MODULUS));
                for (int i = 0; i < 8; i++)
                begin
                    r.bcd[4*i +: 4] = 4'(m % 10);
                    m = m / 10;
                end
                if (sgn && neg)
                    r.bcd[SIGN_BIT] = 1'b1;
            end
            else
            begin
                neg = sgn && it.bcd[SIGN_BIT];
                digits = it.bcd;
                if (sgn)
                    digits[SIGN_BIT] = 1'b0;
                ok = 1'b1;
                acc = '0;
                for (int i = 7; i >= 0; i--)
                begin
                    d = digits[4*i +: 4];
                    if (d > DIGIT_MAX)
                        ok = 1'b0;
                    acc = acc * 10 + 32'(d);
                end
                if (!ok)
                    r.status = STATUS_BAD_DIGIT;
                else
                    r.value = neg ? (VALUE_W'(0) - acc[VALUE_W-1:0]) : acc[VALUE_W-1:0];
            end
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones, with occasional runs of no idling
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_item(input op_t o, input logic [7:0] t, input logic [7:0] g,
                            input int v, input logic [31:0] b);
        codec_item_t it;
        it.op = o;
        it.top = t;
        it.group = g;
        it.value = VALUE_W'(v);
        it.bcd = b;
        pending_items.push_back(it);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                drive_item <= pending_items.pop_front();
                in_valid <= 1'b1;
                send_gap = pick_gap(send_burst);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to fill the pipeline
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && items_accepted >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(recv_burst);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        codec_result_t exp_res;
        in_fire <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(convert_item(drive_item));
                items_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: bcd_out %h value_out %0d status %0d",
                           bcd_out, value_out, status);
                    errors++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (bcd_out !== exp_res.bcd)
                    begin
                        $error("bcd_out mismatch: expected %h, actual %h", exp_res.bcd, bcd_out);
                        errors++;
                    end
                    if (value_out !== exp_res.value)
                    begin
                        $error("value_out mismatch: expected %0d, actual %0d",
                               exp_res.value, value_out);
                        errors++;
                    end
                    if (status !== exp_res.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_res.status, status);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int sel;
        int v;
        int p;
        logic [31:0] b;
        op_t o;
        logic [7:0] t;
        logic [7:0] g;

        // encode extremes, unsigned groups
        add_item(OP_ENCODE, 8'h00, 8'h01, 0, 32'h0);
        add_item(OP_ENCODE, 8'h00, 8'h02, 99999999, 32'hFFFFFFFF);
        add_item(OP_ENCODE, 8'h00, 8'h41, -99999999, 32'h0);
        add_item(OP_ENCODE, 8'h00, 8'hFF, -(1 << 27), 32'h12345678);
        add_item(OP_ENCODE, 8'h00, 8'h05, (1 << 27) - 1, 32'h0);
        // encode, signed groups, values near the modulus and negative values
        add_item(OP_ENCODE, 8'h00, signed_groups[0], 79999999, 32'h0);
        add_item(OP_ENCODE, 8'h00, signed_groups[1], 80000000, 32'h0);
        add_item(OP_ENCODE, 8'h00, signed_groups[2], -80000000, 32'h0);
        add_item(OP_ENCODE, 8'h00, signed_groups[3], -1, 32'h0);
        add_item(OP_ENCODE, 8'h00, signed_groups[4], -(1 << 27), 32'h0);
        // decode
        add_item(OP_DECODE, 8'h00, 8'h01, 0, 32'h99999999);
        add_item(OP_DECODE, 8'h00, 8'h16, -1, 32'h00000000);
        add_item(OP_DECODE, 8'h00, signed_groups[5], 0, 32'h80000000);
        add_item(OP_DECODE, 8'h00, signed_groups[6], 0, 32'h99999999);
        add_item(OP_DECODE, 8'h00, signed_groups[7], 0, 32'h79999999);
        // invalid digits
        add_item(OP_DECODE, 8'h00, 8'h01, 0, 32'h0000000A);
        add_item(OP_DECODE, 8'h00, 8'h3E, 0, 32'hA0000000);
        add_item(OP_DECODE, 8'h00, signed_groups[8], 0, 32'hFA000000);
        add_item(OP_DECODE, 8'h00, signed_groups[0], 0, 32'h8000000F);
        add_item(OP_DECODE, 8'h00, 8'h80, 0, 32'hFFFFFFFF);
        // no format
        add_item(OP_ENCODE, 8'h01, signed_groups[1], 12345678, 32'h0);
        add_item(OP_DECODE, 8'hFF, 8'h01, -5, 32'h12345678);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            o = op_t'($urandom_range(0, 1));
            t = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
            g = $urandom_range(0, 1) ? signed_groups[$urandom_range(0, 8)]
                                     : 8'($urandom_range(0, 255));
            sel = $urandom_range(0, 9);
            if (sel < 4)
                v = int'($urandom());
            else if (sel < 7)
                v = $urandom_range(0, 1) ? int'($urandom_range(0, 99999999))
                                         : -int'($urandom_range(0, 99999999));
            else if (sel == 7)
                v = $urandom_range(0, 1) ? -80000000 + int'($urandom_range(0, 2)) - 1
                                         : 80000000 + int'($urandom_range(0, 2)) - 1;
            else if (sel == 8)
                v = int'($urandom_range(0, 2000)) - 1000;
            else
                v = $urandom_range(0, 1) ? -(1 << 27) : (1 << 27) - 1;
            sel = $urandom_range(0, 9);
            if (sel < 6)
            begin
                for (int i = 0; i < 8; i++)
                    b[4*i +: 4] = 4'($urandom_range(0, 9));
                if ($urandom_range(0, 1))
                    b[SIGN_BIT] = 1'b1;
            end
            else if (sel < 8)
            begin
                for (int i = 0; i < 8; i++)
                    b[4*i +: 4] = 4'($urandom_range(0, 9));
                p = $urandom_range(0, 7);
                b[4*p +: 4] = 4'($urandom_range(10, 15));
            end
            else
            begin
                b = $urandom();
            end
            add_item(o, t, g, v, b);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mbvc_pkg.sv
rtl/meter_bcd_value_codec_unit.sv
test/testbench.sv
